@@ hdl/mhpq_pkg.sv @@
// ============================================================================
// mhpq_pkg
// Shared constants and controller/datapath interface types for the max-heap.
// ============================================================================
`default_nettype none

package mhpq_pkg;

    // Heap geometry.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int DATA_W   = 32;

    // Most negative value, reported when there is no value to report.
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       begin_ins;    // start an insert at the first free slot
        logic       begin_rem;    // take the root out and shrink the count
        logic       begin_fault;  // rejected operation, nothing changes
        logic [1:0] fault_code;   // status reported with begin_fault
        logic       rd_parent;    // read the parent of the current slot
        logic       rd_last;      // read the old last entry
        logic       take_last;    // latch the last entry as the moving value
        logic       rd_kids;      // read both children of the current slot
        logic       move_parent;  // parent drops into the slot, go up
        logic       move_child;   // larger child rises into the slot, go down
        logic       put_value;    // moving value settles in the current slot
        logic       load_out;     // capture the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;       // count equals capacity
        logic empty;      // count is zero
        logic cnt_one;    // exactly one entry stored
        logic pos_zero;   // current slot is the root
        logic up_gt;      // moving value is greater than its parent
        logic kid_in;     // left child lies inside the heap
        logic kid_gt;     // chosen child is greater than the moving value
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/mhpq_datapath.sv @@
// ============================================================================
// mhpq_datapath
// Heap storage, sift position and value registers, comparators and result.
// ============================================================================
`default_nettype none

module mhpq_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [mhpq_pkg::DATA_W-1:0]   new_value,
    input  wire mhpq_pkg::dp_cmd_t                    cmd,
    output mhpq_pkg::dp_stat_t                        stat,
    output logic signed [mhpq_pkg::DATA_W-1:0]        removed_value,
    output logic signed [mhpq_pkg::DATA_W-1:0]        top_value,
    output logic        [mhpq_pkg::CNT_W-1:0]         count_now,
    output logic                                      is_empty,
    output logic        [1:0]                         status
);

    localparam int AW = mhpq_pkg::ADDR_W;
    localparam int DW = mhpq_pkg::DATA_W;
    localparam int CW = mhpq_pkg::CNT_W;

    logic signed [DW-1:0] mem [mhpq_pkg::CAPACITY];

    logic        [CW-1:0] count_reg;
    logic        [AW-1:0] pos_reg;
    logic        [AW-1:0] lim_reg;
    logic signed [DW-1:0] val_reg;
    logic signed [DW-1:0] top_reg;
    logic signed [DW-1:0] rem_reg;
    logic        [1:0]    stat_reg;
    logic signed [DW-1:0] rd_a_reg;
    logic signed [DW-1:0] rd_b_reg;

    logic signed [DW-1:0] out_rem_reg;
    logic signed [DW-1:0] out_top_reg;
    logic        [CW-1:0] out_cnt_reg;
    logic                 out_empty_reg;
    logic        [1:0]    out_stat_reg;

    logic        [AW-1:0] parent;
    logic        [AW:0]   left_idx;
    logic        [AW+1:0] right_idx;
    logic                 right_in;
    logic                 pick_right;
    logic signed [DW-1:0] kid_val;
    logic        [AW-1:0] kid_idx;
    logic        [AW-1:0] addr_a;
    logic        [AW-1:0] addr_b;
    logic                 we;
    logic signed [DW-1:0] wdata;

    assign parent    = AW'((pos_reg - 1'b1) >> 1);
    assign left_idx  = {pos_reg, 1'b1};
    assign right_idx = {1'b0, pos_reg, 1'b0} + (AW+2)'(2);
    assign right_in  = right_idx < {2'b00, lim_reg};
    // On a tie the right child wins.
    assign pick_right = right_in && !(rd_a_reg > rd_b_reg);
    assign kid_val    = pick_right ? rd_b_reg : rd_a_reg;
    assign kid_idx    = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

    always_comb
    begin
        addr_a = parent;
        addr_b = right_idx[AW-1:0];
        if (cmd.rd_last)
        begin
            addr_a = lim_reg;
        end
        else if (cmd.rd_kids)
        begin
            addr_a = left_idx[AW-1:0];
        end
        else if (cmd.rd_parent)
        begin
            addr_a = parent;
        end
    end

    always_comb
    begin
        we    = cmd.move_parent | cmd.move_child | cmd.put_value;
        wdata = val_reg;
        if (cmd.move_parent)
        begin
            wdata = rd_a_reg;
        end
        else if (cmd.move_child)
        begin
            wdata = kid_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[pos_reg] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.begin_ins)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.begin_rem)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_ins)
        begin
            pos_reg  <= count_reg[AW-1:0];
            val_reg  <= new_value;
            rem_reg  <= mhpq_pkg::INT_MIN;
            stat_reg <= mhpq_pkg::STATUS_OK;
        end
        else if (cmd.begin_rem)
        begin
            lim_reg  <= AW'(count_reg - 1'b1);
            rem_reg  <= top_reg;
            stat_reg <= mhpq_pkg::STATUS_OK;
        end
        else if (cmd.begin_fault)
        begin
            rem_reg  <= mhpq_pkg::INT_MIN;
            stat_reg <= cmd.fault_code;
        end
        else if (cmd.take_last)
        begin
            val_reg <= rd_a_reg;
            pos_reg <= '0;
        end
        else if (cmd.move_parent)
        begin
            pos_reg <= parent;
        end
        else if (cmd.move_child)
        begin
            pos_reg <= kid_idx;
        end

        // The root is mirrored so the top is known without a memory read.
        if (we && (pos_reg == '0))
        begin
            top_reg <= wdata;
        end

        if (cmd.load_out)
        begin
            out_rem_reg   <= rem_reg;
            out_top_reg   <= (count_reg == '0) ? mhpq_pkg::INT_MIN : top_reg;
            out_cnt_reg   <= count_reg;
            out_empty_reg <= (count_reg == '0);
            out_stat_reg  <= stat_reg;
        end
    end

    always_comb
    begin
        stat.full     = (count_reg == CW'(mhpq_pkg::CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.cnt_one  = (count_reg == CW'(1));
        stat.pos_zero = (pos_reg == '0);
        stat.up_gt    = (val_reg > rd_a_reg);
        stat.kid_in   = (left_idx < {1'b0, lim_reg});
        stat.kid_gt   = (kid_val > val_reg);
    end

    assign removed_value = out_rem_reg;
    assign top_value     = out_top_reg;
    assign count_now     = out_cnt_reg;
    assign is_empty      = out_empty_reg;
    assign status        = out_stat_reg;

endmodule

`default_nettype wire

@@ hdl/mhpq_controller.sv @@
// ============================================================================
// mhpq_controller
// Sequencer for insert and remove, driving the sift loops and the output slot.
// ============================================================================
`default_nettype none

module mhpq_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                opcode,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire mhpq_pkg::dp_stat_t  stat,
    output mhpq_pkg::dp_cmd_t        cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_RD   = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_LD_RD   = 8'b0000_1000,
        S_LD_TAKE = 8'b0001_0000,
        S_DN_RD   = 8'b0010_0000,
        S_DN_CMP  = 8'b0100_0000,
        S_RESULT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == mhpq_pkg::OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.begin_fault = 1'b1;
                            cmd.fault_code  = mhpq_pkg::STATUS_FULL;
                            state_next      = S_RESULT;
                        end
                        else
                        begin
                            cmd.begin_ins = 1'b1;
                            state_next    = S_UP_RD;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.begin_fault = 1'b1;
                        cmd.fault_code  = mhpq_pkg::STATUS_EMPTY;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        cmd.begin_rem = 1'b1;
                        state_next    = stat.cnt_one ? S_RESULT : S_LD_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.put_value = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_gt)
                begin
                    cmd.move_parent = 1'b1;
                    state_next      = S_UP_RD;
                end
                else
                begin
                    cmd.put_value = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_LD_RD:
            begin
                cmd.rd_last = 1'b1;
                state_next  = S_LD_TAKE;
            end
            S_LD_TAKE:
            begin
                cmd.take_last = 1'b1;
                state_next    = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (stat.kid_in)
                begin
                    cmd.rd_kids = 1'b1;
                    state_next  = S_DN_CMP;
                end
                else
                begin
                    cmd.put_value = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_DN_CMP:
            begin
                if (stat.kid_gt)
                begin
                    cmd.move_child = 1'b1;
                    state_next     = S_DN_RD;
                end
                else
                begin
                    cmd.put_value = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/max_heap_priority_queue_core.sv @@
// ============================================================================
// max_heap_priority_queue_core
// Binary max-heap priority queue of signed 32-bit values with stream ports.
// ============================================================================
//
//  Channel  Dir  Width        Contents
//  s_*      in   tdata 32     new_value; tuser 1: opcode (0 insert, 1 remove)
//  m_*      out  tdata 72     removed_value, top_value, count_now, is_empty;
//                tuser 2      status (0 ok, 1 remove on empty, 2 full drop)
//
// An insert puts the new value in the first free slot and sifts it up past each
// smaller parent; a removal takes the root out, moves the old last entry to the
// root and sifts it down past the larger child. Rejected operations and a
// removal of the only entry go straight to the result. Reset clears the entry
// count and the output slot; the heap memory needs no clearing. A stalled
// result waits in the output register while the next transaction is worked on.
//
`default_nettype none

module max_heap_priority_queue_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] new_value
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] removed_value, [63:32] top_value,
                                        // [70:64] count_now, [71] is_empty
    output logic [1:0]       m_tuser    // [1:0] status
);

    mhpq_pkg::dp_cmd_t  cmd;
    mhpq_pkg::dp_stat_t stat;

    logic signed [mhpq_pkg::DATA_W-1:0] removed_value;
    logic signed [mhpq_pkg::DATA_W-1:0] top_value;
    logic        [mhpq_pkg::CNT_W-1:0]  count_now;
    logic                               is_empty;
    logic        [1:0]                  status;

    // The controller sequences each transaction; the datapath holds the heap.
    mhpq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser[0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mhpq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .new_value     (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .removed_value (removed_value),
        .top_value     (top_value),
        .count_now     (count_now),
        .is_empty      (is_empty),
        .status        (status)
    );

    // Result fields packed from the lowest bit up; 72 bits fill nine bytes.
    assign m_tdata = {is_empty, count_now, top_value, removed_value};
    assign m_tuser = status;

endmodule

`default_nettype wire
